### hw/rtl/qah_pkg.sv
// shared constants and edge tables for the quadrilateral area unit
`timescale 1ns / 1ps

package qah_pkg;

   localparam int COORD_BITS_DEFAULT      = 16;
   localparam int COORD_FRAC_BITS_DEFAULT = 4;
   localparam int AREA_FRAC_BITS_DEFAULT  = 8;
   localparam int LEN_EXTRA_BITS          = 8;
   localparam int AREA_BITS               = 32;
   localparam int NUM_CORNERS             = 4;
   localparam int NUM_EDGES               = 5;
   localparam int NUM_TRIS                = 2;

   // edges 0-1, 0-3, 1-3, 1-2, 2-3
   localparam int EDGE_A [NUM_EDGES] = '{0, 0, 1, 1, 2};
   localparam int EDGE_B [NUM_EDGES] = '{1, 3, 3, 2, 3};

   // triangle (0,1,3) and triangle (1,2,3), sides given as edge numbers
   localparam int TRI_A [NUM_TRIS] = '{0, 3};
   localparam int TRI_B [NUM_TRIS] = '{1, 4};
   localparam int TRI_C [NUM_TRIS] = '{2, 2};

endpackage

### hw/rtl/quad_area_heron_unit.sv
// quadrilateral area by heron's formula over the 1-3 diagonal, fully pipelined
`timescale 1ns / 1ps
//
// usage
//   a word of four corners (req_x0 .. req_y3, unsigned, COORD_FRAC_BITS fraction
//   bits) is taken at each clock edge with start high; busy is always low, so a
//   new word may enter every cycle
//   the area (unsigned, AREA_FRAC_BITS fraction bits, saturated to 32 bits) is
//   shown on rsp_area for one cycle with rsp_strobe high, in input order
//   stages: input register, edge differences and squares, edge roots, heron
//   factors and products, triangle roots, output; each root takes one stage per
//   root bit, LW = COORD_BITS + LEN_EXTRA_BITS + 1 for edges, RW for triangles
//   throughput: one word per cycle
//   reset clears every valid bit in the pipeline; words in flight are dropped
//   the receiver cannot stall, results leave on a fixed schedule
//
module quad_area_heron_unit #(
   parameter int COORD_BITS      = qah_pkg::COORD_BITS_DEFAULT,
   parameter int COORD_FRAC_BITS = qah_pkg::COORD_FRAC_BITS_DEFAULT,
   parameter int AREA_FRAC_BITS  = qah_pkg::AREA_FRAC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [COORD_BITS-1:0]         req_x0,
   input  logic [COORD_BITS-1:0]         req_y0,
   input  logic [COORD_BITS-1:0]         req_x1,
   input  logic [COORD_BITS-1:0]         req_y1,
   input  logic [COORD_BITS-1:0]         req_x2,
   input  logic [COORD_BITS-1:0]         req_y2,
   input  logic [COORD_BITS-1:0]         req_x3,
   input  logic [COORD_BITS-1:0]         req_y3,
   output logic                          rsp_strobe,
   output logic [qah_pkg::AREA_BITS-1:0] rsp_area
);

   import qah_pkg::*;

   localparam int C    = COORD_BITS;
   localparam int SqW  = 2 * C;
   localparam int D2W  = 2 * C + 1;
   localparam int LW   = C + LEN_EXTRA_BITS + 1;
   localparam int LRW  = 2 * LW;
   localparam int UW   = LW + 2;
   localparam int VW   = LW + 1;
   localparam int AW   = UW + VW;
   localparam int BW   = 2 * VW;
   localparam int AL   = (AW + 1) / 2;
   localparam int AH   = AW - AL;
   localparam int BL   = (BW + 1) / 2;
   localparam int BH   = BW - BL;
   localparam int M1W  = AL + BW;
   localparam int M2W  = AH + BW;
   localparam int PW   = AW + BW;
   localparam int RW   = (PW + 2 * AREA_FRAC_BITS + 1) / 2;
   localparam int RRW  = 2 * RW;
   localparam int SW   = RW + 1;
   localparam int SH   = 2 * (COORD_FRAC_BITS + LEN_EXTRA_BITS) + 2;
   localparam int EW   = (SW > SH + AREA_BITS) ? SW : SH + AREA_BITS + 1;

   // input stage
   logic          vld0_ff;
   logic [C-1:0]  px_ff [NUM_CORNERS];
   logic [C-1:0]  py_ff [NUM_CORNERS];

   always_ff @(posedge clock) begin
      px_ff[0] <= req_x0;
      py_ff[0] <= req_y0;
      px_ff[1] <= req_x1;
      py_ff[1] <= req_y1;
      px_ff[2] <= req_x2;
      py_ff[2] <= req_y2;
      px_ff[3] <= req_x3;
      py_ff[3] <= req_y3;
      if (reset) begin
         vld0_ff <= 1'b0;
      end else begin
         vld0_ff <= start;
      end
   end

   assign busy = 1'b0;

   // edge lengths
   logic                  vld1_ff, vld2_ff;
   logic [C-1:0]          dx_ff   [NUM_EDGES];
   logic [C-1:0]          dy_ff   [NUM_EDGES];
   logic [SqW-1:0]        dxsq_ff [NUM_EDGES];
   logic [SqW-1:0]        dysq_ff [NUM_EDGES];
   logic [LW-1:0]         len_w   [NUM_EDGES];
   logic [NUM_EDGES-1:0]  len_vld;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld1_ff <= vld0_ff;
         vld2_ff <= vld1_ff;
      end
   end

   for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge
      logic [C-1:0]   xa, xb, ya, yb;
      logic [C-1:0]   dx_in, dy_in;
      logic [D2W-1:0] d2_w;
      logic [LRW-1:0] rad_w;

      always_comb begin
         xa    = px_ff[EDGE_A[e]];
         xb    = px_ff[EDGE_B[e]];
         ya    = py_ff[EDGE_A[e]];
         yb    = py_ff[EDGE_B[e]];
         dx_in = (xa > xb) ? (xa - xb) : (xb - xa);
         dy_in = (ya > yb) ? (ya - yb) : (yb - ya);
         d2_w  = D2W'(dxsq_ff[e]) + D2W'(dysq_ff[e]);
         rad_w = LRW'(d2_w) << (2 * LEN_EXTRA_BITS);
      end

      always_ff @(posedge clock) begin
         dx_ff[e]   <= dx_in;
         dy_ff[e]   <= dy_in;
         dxsq_ff[e] <= dx_ff[e] * dx_ff[e];
         dysq_ff[e] <= dy_ff[e] * dy_ff[e];
      end

      qah_sqrt_pipe #(
         .RES_BITS (LW)
      ) u_len_root (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld2_ff),
         .in_rad    (rad_w),
         .out_valid (len_vld[e]),
         .out_root  (len_w[e])
      );
   end

   // heron factors, products and triangle roots
   logic                 vld4_ff, vld5_ff, vld6_ff, vld7_ff, vld8_ff;
   logic [NUM_TRIS-1:0]  tri_vld;
   logic [RW-1:0]        root_w [NUM_TRIS];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
         vld6_ff <= 1'b0;
         vld7_ff <= 1'b0;
         vld8_ff <= 1'b0;
      end else begin
         vld4_ff <= &len_vld;
         vld5_ff <= vld4_ff;
         vld6_ff <= vld5_ff;
         vld7_ff <= vld6_ff;
         vld8_ff <= vld7_ff;
      end
   end

   for (genvar t = 0; t < NUM_TRIS; t++) begin : g_tri
      logic [LW-1:0]     a, b, c;
      logic [VW-1:0]     bc, ac, ab;
      logic [UW-1:0]     u_in;
      logic [VW-1:0]     v_in, w_in, z_in;
      logic              neg_in;
      logic [UW-1:0]     u_ff;
      logic [VW-1:0]     v_ff, w_ff, z_ff;
      logic              neg4_ff, neg5_ff, neg6_ff, neg7_ff;
      logic [AW-1:0]     uv_ff;
      logic [BW-1:0]     wz_ff;
      logic [AL+BL-1:0]  pp_ll_ff;
      logic [AL+BH-1:0]  pp_lh_ff;
      logic [AH+BL-1:0]  pp_hl_ff;
      logic [AH+BH-1:0]  pp_hh_ff;
      logic [M1W-1:0]    m1_in, m1_ff;
      logic [M2W-1:0]    m2_in, m2_ff;
      logic [PW-1:0]     p_in, p_ff;
      logic [RRW-1:0]    rad_w;

      always_comb begin
         a      = len_w[TRI_A[t]];
         b      = len_w[TRI_B[t]];
         c      = len_w[TRI_C[t]];
         bc     = VW'(b) + VW'(c);
         ac     = VW'(a) + VW'(c);
         ab     = VW'(a) + VW'(b);
         u_in   = UW'(ab) + UW'(c);
         v_in   = bc - VW'(a);
         w_in   = ac - VW'(b);
         z_in   = ab - VW'(c);
         neg_in = (bc < VW'(a)) || (ac < VW'(b)) || (ab < VW'(c));
         m1_in  = M1W'(pp_ll_ff) + (M1W'(pp_lh_ff) << BL);
         m2_in  = M2W'(pp_hl_ff) + (M2W'(pp_hh_ff) << BL);
         p_in   = neg7_ff ? '0 : (PW'(m1_ff) + (PW'(m2_ff) << AL));
         rad_w  = RRW'(p_ff) << (2 * AREA_FRAC_BITS);
      end

      always_ff @(posedge clock) begin
         u_ff     <= u_in;
         v_ff     <= v_in;
         w_ff     <= w_in;
         z_ff     <= z_in;
         neg4_ff  <= neg_in;
         uv_ff    <= AW'(u_ff) * AW'(v_ff);
         wz_ff    <= BW'(w_ff) * BW'(z_ff);
         neg5_ff  <= neg4_ff;
         pp_ll_ff <= (AL+BL)'(uv_ff[AL-1:0]) * (AL+BL)'(wz_ff[BL-1:0]);
         pp_lh_ff <= (AL+BH)'(uv_ff[AL-1:0]) * (AL+BH)'(wz_ff[BW-1:BL]);
         pp_hl_ff <= (AH+BL)'(uv_ff[AW-1:AL]) * (AH+BL)'(wz_ff[BL-1:0]);
         pp_hh_ff <= (AH+BH)'(uv_ff[AW-1:AL]) * (AH+BH)'(wz_ff[BW-1:BL]);
         neg6_ff  <= neg5_ff;
         m1_ff    <= m1_in;
         m2_ff    <= m2_in;
         neg7_ff  <= neg6_ff;
         p_ff     <= p_in;
      end

      qah_sqrt_pipe #(
         .RES_BITS (RW)
      ) u_tri_root (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld8_ff),
         .in_rad    (rad_w),
         .out_valid (tri_vld[t]),
         .out_root  (root_w[t])
      );
   end

   // sum, scale and saturate
   logic [SW-1:0]        sum_w;
   logic [EW-1:0]        ext_w;
   logic [AREA_BITS-1:0] area_in;
   logic                 out_vld_ff;
   logic [AREA_BITS-1:0] area_ff;

   always_comb begin
      sum_w   = SW'(root_w[0]) + SW'(root_w[1]);
      ext_w   = EW'(sum_w);
      area_in = (|ext_w[EW-1:SH+AREA_BITS]) ? '1 : ext_w[SH+AREA_BITS-1:SH];
   end

   always_ff @(posedge clock) begin
      area_ff <= area_in;
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= &tri_vld;
      end
   end

   assign rsp_strobe = out_vld_ff;
   assign rsp_area   = area_ff;

endmodule

### hw/rtl/qah_sqrt_pipe.sv
// pipelined integer square root, one result bit per register stage
`timescale 1ns / 1ps

module qah_sqrt_pipe #(
   parameter int RES_BITS = 25
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [2*RES_BITS-1:0]   in_rad,
   output logic                    out_valid,
   output logic [RES_BITS-1:0]     out_root
);

   localparam int RadW = 2 * RES_BITS;
   localparam int RemW = RES_BITS + 2;
   localparam int CmpW = RES_BITS + 4;

   logic [RemW-1:0]     rem_ff  [RES_BITS];
   logic [RES_BITS-1:0] root_ff [RES_BITS];
   logic [RadW-1:0]     rad_ff  [RES_BITS];
   logic [RES_BITS-1:0] vld_ff;

   for (genvar k = 0; k < RES_BITS; k++) begin : g_stage
      logic [RemW-1:0]     rem_s;
      logic [RES_BITS-1:0] root_s;
      logic [RadW-1:0]     rad_s;
      logic                vld_s;
      logic [CmpW-1:0]     cur_w, trial_w, diff_w;
      logic                take;
      logic [RemW-1:0]     rem_in;
      logic [RES_BITS-1:0] root_in;
      logic [RadW-1:0]     rad_in;

      if (k == 0) begin : g_first
         assign rem_s  = '0;
         assign root_s = '0;
         assign rad_s  = in_rad;
         assign vld_s  = in_valid;
      end else begin : g_next
         assign rem_s  = rem_ff[k-1];
         assign root_s = root_ff[k-1];
         assign rad_s  = rad_ff[k-1];
         assign vld_s  = vld_ff[k-1];
      end

      always_comb begin
         cur_w   = {rem_s, rad_s[RadW-1 -: 2]};
         trial_w = {2'b00, root_s, 2'b01};
         diff_w  = cur_w - trial_w;
         take    = (cur_w >= trial_w);
         rem_in  = take ? diff_w[RemW-1:0] : cur_w[RemW-1:0];
         root_in = {root_s[RES_BITS-2:0], take};
         rad_in  = {rad_s[RadW-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         rad_ff[k]  <= rad_in;
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_s;
         end
      end
   end

   assign out_valid = vld_ff[RES_BITS-1];
   assign out_root  = root_ff[RES_BITS-1];

endmodule

### test/tb_quad_area_heron_unit.sv
// testbench for the quadrilateral area unit: directed and random corner words against a bit-exact predictor
`timescale 1ns / 1ps

module tb_quad_area_heron_unit;
   import qah_pkg::*;

   localparam int CB        = COORD_BITS_DEFAULT;
   localparam int CFB       = COORD_FRAC_BITS_DEFAULT;
   localparam int AFB       = AREA_FRAC_BITS_DEFAULT;
   localparam int LIMIT     = 200000;
   localparam int SETTLE    = 250;
   localparam int OUT_SHIFT = 2 * (CFB + LEN_EXTRA_BITS) + 2;

   typedef logic [255:0] wide_type;
   typedef struct {
      logic [CB-1:0] x [NUM_CORNERS];
      logic [CB-1:0] y [NUM_CORNERS];
      bit            drain;
   } quad_type;

   logic clock, reset, start, busy, rsp_strobe;
   logic [CB-1:0] req_x0, req_y0, req_x1, req_y1, req_x2, req_y2, req_x3, req_y3;
   logic [AREA_BITS-1:0] rsp_area;

   quad_type pending_quads [$];
   logic [AREA_BITS-1:0] expected_areas [$];
   int errors = 0;
   int cycles = 0;
   int gap = 0;
   bit quiet_phase = 0;

   quad_area_heron_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_x0(req_x0), .req_y0(req_y0), .req_x1(req_x1), .req_y1(req_y1),
      .req_x2(req_x2), .req_y2(req_y2), .req_x3(req_x3), .req_y3(req_y3),
      .rsp_strobe(rsp_strobe), .rsp_area(rsp_area)
   );

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   function automatic wide_type isqrt(wide_type n);
      wide_type res, bit_w;
      res = '0;
      bit_w = wide_type'(1) << 254;
      while (bit_w > n) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (n >= res + bit_w) begin
            n = n - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   function automatic longint edge_len(logic [CB-1:0] xa, logic [CB-1:0] ya,
                                       logic [CB-1:0] xb, logic [CB-1:0] yb);
      wide_type dx, dy;
      dx = (xa > xb) ? wide_type'(xa - xb) : wide_type'(xb - xa);
      dy = (ya > yb) ? wide_type'(ya - yb) : wide_type'(yb - ya);
      return longint'(isqrt((dx * dx + dy * dy) << (2 * LEN_EXTRA_BITS)));
   endfunction

   function automatic wide_type tri_root(longint a, longint b, longint c);
      longint u, v, w, z;
      u = a + b + c;
      v = b + c - a;
      w = a + c - b;
      z = a + b - c;
      if (v < 0 || w < 0 || z < 0) return '0;
      return isqrt((wide_type'(u) * wide_type'(v) * wide_type'(w) * wide_type'(z))
                   << (2 * AFB));
   endfunction

   function automatic logic [AREA_BITS-1:0] quad_area(quad_type q);
      longint d01, d03, d13, d12, d23;
      wide_type sum;
      d01 = edge_len(q.x[0], q.y[0], q.x[1], q.y[1]);
      d03 = edge_len(q.x[0], q.y[0], q.x[3], q.y[3]);
      d13 = edge_len(q.x[1], q.y[1], q.x[3], q.y[3]);
      d12 = edge_len(q.x[1], q.y[1], q.x[2], q.y[2]);
      d23 = edge_len(q.x[2], q.y[2], q.x[3], q.y[3]);
      sum = (tri_root(d01, d03, d13) + tri_root(d12, d23, d13)) >> OUT_SHIFT;
      return (sum >> AREA_BITS) != 0 ? {AREA_BITS{1'b1}} : sum[AREA_BITS-1:0];
   endfunction

   task automatic report(string what, logic [AREA_BITS-1:0] got, logic [AREA_BITS-1:0] want);
      $display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
      errors++;
   endtask

   task automatic add_quad(int c0x, int c0y, int c1x, int c1y, int c2x, int c2y,
                           int c3x, int c3y, bit drain = 0);
      quad_type q;
      q.x[0] = CB'(c0x); q.y[0] = CB'(c0y); q.x[1] = CB'(c1x); q.y[1] = CB'(c1y);
      q.x[2] = CB'(c2x); q.y[2] = CB'(c2y); q.x[3] = CB'(c3x); q.y[3] = CB'(c3y);
      q.drain = drain;
      pending_quads = {pending_quads, q};
   endtask

   task automatic add_random_quad();
      quad_type q;
      int cx, cy, r, mode;
      mode = $urandom_range(0, 9);
      cx = $urandom_range(4096, 61439);
      cy = $urandom_range(4096, 61439);
      for (int i = 0; i < NUM_CORNERS; i++) begin
         if (mode < 5) begin
            // plausible marker: corners around a centre
            r = $urandom_range(0, 4000);
            q.x[i] = CB'(cx + ((i == 1 || i == 2) ? r : -r) + $urandom_range(0, 200) - 100);
            r = $urandom_range(0, 4000);
            q.y[i] = CB'(cy + ((i >= 2) ? r : -r) + $urandom_range(0, 200) - 100);
         end else begin
            q.x[i] = CB'($urandom);
            q.y[i] = CB'($urandom);
         end
      end
      if (mode == 9) begin
         q.x[$urandom_range(0, 3)] = q.x[1];
         q.y[3] = q.y[1];
         q.x[3] = q.x[1];
      end
      q.drain = ($urandom_range(0, 99) == 0);
      pending_quads = {pending_quads, q};
   endtask

   // driver
   always @(posedge clock) begin
      quad_type q;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            q.x[0] = req_x0; q.y[0] = req_y0; q.x[1] = req_x1; q.y[1] = req_y1;
            q.x[2] = req_x2; q.y[2] = req_y2; q.x[3] = req_x3; q.y[3] = req_y3;
            expected_areas = {expected_areas, quad_area(q)};
            gap = quiet_phase ? 0 :
                  ($urandom_range(0, 9) < 6 ? 0 :
                   ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(10, 40)));
         end
         if (start && busy) begin
            start <= 1'b1;
         end else if (gap > 0 || pending_quads.size() == 0) begin
            if (gap > 0) gap--;
            start <= 1'b0;
         end else if (pending_quads[0].drain && expected_areas.size() != 0) begin
            start <= 1'b0;
         end else begin
            q = pending_quads.pop_front();
            req_x0 <= q.x[0]; req_y0 <= q.y[0]; req_x1 <= q.x[1]; req_y1 <= q.y[1];
            req_x2 <= q.x[2]; req_y2 <= q.y[2]; req_x3 <= q.x[3]; req_y3 <= q.y[3];
            start <= 1'b1;
            if ($urandom_range(0, 63) == 0) quiet_phase = !quiet_phase;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cycles++;
      if (!reset && rsp_strobe) begin
         if (expected_areas.size() == 0)
            report("unexpected word", rsp_area, '0);
         else if (rsp_area !== expected_areas[0])
            report("area", rsp_area, expected_areas.pop_front());
         else
            void'(expected_areas.pop_front());
      end
      if (cycles > LIMIT) begin
         $display("tb_quad_area_heron_unit failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      {req_x0, req_y0, req_x1, req_y1, req_x2, req_y2, req_x3, req_y3} = '0;
      add_quad(0, 0, 0, 0, 0, 0, 0, 0);
      add_quad(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535);
      add_quad(0, 0, 65535, 0, 65535, 65535, 0, 65535);
      add_quad(0, 0, 0, 65535, 65535, 65535, 65535, 0);
      add_quad(16, 16, 32, 16, 32, 32, 16, 32);
      add_quad(0, 0, 1, 0, 1, 1, 0, 1);
      add_quad(100, 100, 200, 200, 300, 300, 400, 400);
      add_quad(0, 0, 65535, 65535, 0, 0, 65535, 65535);
      add_quad(500, 500, 500, 500, 900, 700, 500, 500);
      add_quad(1000, 1000, 3000, 1000, 2000, 1001, 1000, 1001);
      add_quad(1, 2, 3, 4, 5, 6, 7, 9);
      add_quad(43690, 21845, 21845, 43690, 43690, 65535, 65535, 43690);
      add_quad(32768, 0, 65535, 32768, 32768, 65535, 0, 32768, 1);
      add_quad(65535, 0, 0, 65535, 65535, 65535, 65535, 0);
      add_quad(12345, 54321, 12346, 54321, 12346, 54322, 12345, 54322);
      add_quad(0, 65535, 65535, 0, 65535, 65535, 0, 0);
      for (int i = 0; i < 450; i++) add_random_quad();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait (pending_quads.size() == 0 && !start && expected_areas.size() == 0);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0)
         $display("tb_quad_area_heron_unit passed");
      else
         $display("tb_quad_area_heron_unit failed");
      $finish;
   end

endmodule
